[rtl/fixed_window_message_limiter_assert.svh]
// Assertion macros for the fixed-window message limiter.
// Taken in by the controller and datapath; needs no other file.
`ifndef FIXED_WINDOW_MESSAGE_LIMITER_ASSERT_SVH
`define FIXED_WINDOW_MESSAGE_LIMITER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define FWML_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define FWML_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/fwml_pkg.sv]
// Shared types and constants for the fixed-window message limiter.
// No dependencies; used by the controller, datapath and top level.
`default_nettype none

package fwml_pkg;

    // counter table: one entry per possible sender index
    localparam int MAX_USERS = 256;
    localparam int UID_W     = $clog2(MAX_USERS);
    localparam int CNT_W     = 16;
    localparam int TIME_W    = 32;
    localparam int DL_W      = TIME_W + 1;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PER_USER   = 2'd2;

    localparam logic [CNT_W-1:0] LINE_LIMIT_RST = 16'd5;
    localparam logic [CNT_W-1:0] WINDOW_RST     = 16'd10;
    localparam logic [CNT_W-1:0] CNT_MAX        = 16'hFFFF;

    // controller -> datapath
    typedef struct packed {
        logic capture;  // take input transfer, launch counter read
        logic commit;   // update counters, load result register
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic out_free; // result register empty or drained this cycle
    } t_dp_sts;

endpackage

`default_nettype wire

[rtl/fwml_ctrl.sv]
// Controller for the fixed-window message limiter: two-state sequencer.
// Depends on fwml_pkg and fixed_window_message_limiter_assert.svh.
`default_nettype none

`include "fixed_window_message_limiter_assert.svh"

module fwml_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  fwml_pkg::t_dp_sts i_sts,
    output fwml_pkg::t_dp_cmd o_cmd
);
    import fwml_pkg::*;

    localparam logic [0:0] S_IDLE = 1'b0;
    localparam logic [0:0] S_CALC = 1'b1;

    logic [0:0] r_state;
    logic [0:0] n_state;

    // commands
    always_comb begin
        o_in_ready     = (r_state == S_IDLE);
        o_cmd.capture  = o_in_ready && i_in_valid;
        o_cmd.commit   = (r_state == S_CALC) && i_sts.out_free;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.capture) n_state = S_CALC;
            end
            S_CALC: begin
                if (o_cmd.commit) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `FWML_ASSERT_NEXT(a_capture_to_calc, i_clk, i_rst_n, o_cmd.capture, r_state == S_CALC,
        "accepted item did not move to update")
    `FWML_ASSERT_NEXT(a_calc_holds, i_clk, i_rst_n, (r_state == S_CALC) && !i_sts.out_free,
        r_state == S_CALC && !o_in_ready, "update left while result register full")

endmodule

`default_nettype wire

[rtl/fwml_dp.sv]
// Datapath for the fixed-window message limiter: config, window, counters, result.
// Depends on fwml_pkg and fixed_window_message_limiter_assert.svh.
`default_nettype none

`include "fixed_window_message_limiter_assert.svh"

module fwml_dp (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  fwml_pkg::t_dp_cmd              i_cmd,
    output fwml_pkg::t_dp_sts              o_sts,
    input  wire [fwml_pkg::TIME_W-1:0]     i_now_secs,
    input  wire [fwml_pkg::UID_W-1:0]      i_user_id,
    input  wire                            i_local_sender,
    input  wire                            i_applies,
    output logic                           o_out_valid,
    input  wire                            i_out_ready,
    output logic                           o_deny,
    output logic                           o_limit_reached,
    input  wire                            i_cfg_we,
    input  wire [fwml_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [fwml_pkg::CNT_W-1:0]      i_cfg_wdata
);
    import fwml_pkg::*;

    // configuration
    logic [CNT_W-1:0] r_line_limit;
    logic [CNT_W-1:0] r_window;
    logic             r_per_user;

    // captured item
    logic [TIME_W-1:0] r_now;
    logic [UID_W-1:0]  r_uid;
    logic              r_local;
    logic              r_applies;

    // window and counters
    logic [DL_W-1:0]      r_deadline;
    logic                 r_armed;
    logic [CNT_W-1:0]     r_shared;
    logic [MAX_USERS-1:0] r_valid;
    logic [CNT_W-1:0]     r_cnt_mem [MAX_USERS];
    logic [CNT_W-1:0]     r_mem_rdata;

    // result register
    logic r_out_valid;
    logic r_deny;
    logic r_limit;

    logic                 expire;
    logic                 count_user;
    logic                 counted;
    logic [CNT_W-1:0]     base_cnt;
    logic [CNT_W-1:0]     new_cnt;
    logic                 limit;
    logic [DL_W-1:0]      n_deadline;
    logic [MAX_USERS-1:0] n_valid;

    assign o_sts.out_free = !r_out_valid || i_out_ready;

    // config writes; indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_limit <= LINE_LIMIT_RST;
            r_window     <= WINDOW_RST;
            r_per_user   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LINE_LIMIT: r_line_limit <= i_cfg_wdata;
                CFG_WINDOW:     r_window     <= i_cfg_wdata;
                CFG_PER_USER:   r_per_user   <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // input capture and counter read (registered read port)
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_now       <= i_now_secs;
            r_uid       <= i_user_id;
            r_local     <= i_local_sender;
            r_applies   <= i_applies;
            r_mem_rdata <= r_cnt_mem[i_user_id];
        end
    end

    // window check, count select, saturating increment, limit compare
    always_comb begin
        expire     = !r_armed || ({1'b0, r_now} > r_deadline);
        count_user = r_per_user && r_local;
        counted    = r_applies && (!r_per_user || r_local);
        n_deadline = {1'b0, r_now} + {{(DL_W-CNT_W){1'b0}}, r_window};

        if (r_per_user) begin
            base_cnt = (expire || !r_valid[r_uid]) ? '0 : r_mem_rdata;
        end else begin
            base_cnt = expire ? '0 : r_shared;
        end
        new_cnt = (base_cnt == CNT_MAX) ? base_cnt : base_cnt + 1'b1;
        limit   = counted && (new_cnt >= r_line_limit);

        n_valid = expire ? '0 : r_valid;
        if (count_user) n_valid[r_uid] = 1'b1;
    end

    // counter table write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && r_applies && count_user) begin
            r_cnt_mem[r_uid] <= new_cnt;
        end
    end

    // window state, sender valid bits and shared counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadline <= '0;
            r_armed    <= 1'b0;
            r_shared   <= '0;
            r_valid    <= '0;
        end else if (i_cmd.commit && r_applies) begin
            if (expire) begin
                r_deadline <= n_deadline;
                r_armed    <= 1'b1;
            end
            r_valid <= n_valid;
            if (!r_per_user) begin
                r_shared <= new_cnt;
            end else if (expire) begin
                r_shared <= '0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_limit <= limit;
            r_deny  <= limit && r_local;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_deny          = r_deny;
    assign o_limit_reached = r_limit;

    `FWML_ASSERT_NEXT(a_commit_loads, i_clk, i_rst_n, i_cmd.commit, r_out_valid,
        "commit did not load result register")
    `FWML_ASSERT_NOW(a_deny_implies_limit, i_clk, i_rst_n, r_out_valid, !r_deny || r_limit,
        "deny without limit reached")
    `FWML_ASSERT_NEXT(a_window_armed, i_clk, i_rst_n, i_cmd.commit && r_applies, r_armed,
        "counted message left window unarmed")

endmodule

`default_nettype wire

[rtl/fixed_window_message_limiter.sv]
// Top level of the fixed-window message limiter: controller plus datapath.
// Depends on fwml_pkg, fwml_ctrl and fwml_dp.
//
//  channel   handshake                  payload
//  -------   ------------------------   ----------------------------------------
//  input     i_in_valid / o_in_ready    i_now_secs, i_user_id, i_local_sender, i_applies
//  output    o_out_valid / i_out_ready  o_deny, o_limit_reached
//  config    i_cfg_we (no wait)         i_cfg_idx, i_cfg_wdata
//
// For each item the accept cycle captures the input and launches the counter table
// read; the update state then updates the window and counters and loads the result
// register, using the data from the registered read port of the counter table.
// Synchronous active-low reset restores the config defaults, clears the window and
// every sender valid bit; the counter table itself is not cleared.
// A full result register stalls the update cycle; the next item is taken while a
// finished result waits.
`default_nettype none

module fixed_window_message_limiter (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_in_valid,
    output logic                           o_in_ready,
    input  wire [fwml_pkg::TIME_W-1:0]     i_now_secs,
    input  wire [fwml_pkg::UID_W-1:0]      i_user_id,
    input  wire                            i_local_sender,
    input  wire                            i_applies,
    output logic                           o_out_valid,
    input  wire                            i_out_ready,
    output logic                           o_deny,
    output logic                           o_limit_reached,
    input  wire                            i_cfg_we,
    input  wire [fwml_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [fwml_pkg::CNT_W-1:0]      i_cfg_wdata
);
    import fwml_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    fwml_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    fwml_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_now_secs      (i_now_secs),
        .i_user_id       (i_user_id),
        .i_local_sender  (i_local_sender),
        .i_applies       (i_applies),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_deny          (o_deny),
        .o_limit_reached (o_limit_reached),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata)
    );

endmodule

`default_nettype wire
